// ===== sv/sv39pte_pkg.sv =====
// Shared types and constants of the Sv39 page table engine.
`timescale 1ns / 1ps

package sv39pte_pkg;

  localparam int unsigned PoolTables = 64;
  localparam int unsigned TblEntries = 512;
  localparam int unsigned IdxW       = 9;
  localparam int unsigned EntryW     = 54;
  localparam int unsigned PpnW       = 44;
  localparam int unsigned FlagW      = 10;
  localparam int unsigned VaW        = 39;
  localparam int unsigned PaW        = 56;
  localparam int unsigned InDataW    = 112;
  localparam int unsigned OutDataW   = 64;
  localparam int unsigned ApbDataW   = 64;

  localparam logic [FlagW-1:0] EntV   = 10'h001;
  localparam logic [FlagW-1:0] EntRwx = 10'h00E;
  localparam logic [FlagW-1:0] EntAd  = 10'h0C0;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_UNMAP = 2'd1,
    REQ_XLATE = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L2,
    ST_RD1,
    ST_L1,
    ST_RD0,
    ST_L0,
    ST_WLEAF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic          status;
    logic [PaW-1:0] phys;
    logic          flush;
  } result_t;

endpackage

// ===== sv/sv39pte_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sv39pte_ram #(
  parameter int unsigned Width = 54,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sv39_page_table_engine_top.sv =====
// Top level of the Sv39 page table engine: walk sequencer around root and pool RAMs.
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Contents
// s_axis    in   s_tvalid_i/s_tready_o  req_type, virt_addr, phys_addr, leaf_flags
// m_axis    out  m_tvalid_o/m_tready_i  status, phys_out, flush_request
// apb       in   psel_i/penable_i       pool_base_page at address 0
//
// A result word is registered from the final state of the walk, and the sequencer
// then returns to idle for the next word; a translate that reaches a 4 KB leaf
// needs three dependent reads.
// After reset the block clears both RAMs before it accepts a word. Input words are
// taken one at a time; a waiting result word holds the sequencer in its final
// state until the output side takes it.

module sv39_page_table_engine_top
  import sv39pte_pkg::*;
#(
  parameter int unsigned POOL_TABLES = PoolTables
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  // [1:0] req_type, [40:2] virt_addr, [96:41] phys_addr, [106:97] leaf_flags
  input  logic [InDataW-1:0]  s_tdata_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  // [0] status, [56:1] phys_out, [57] flush_request
  output logic [OutDataW-1:0] m_tdata_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [0:0]          paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o
);

  localparam int unsigned PoolDepth = POOL_TABLES * TblEntries;
  localparam int unsigned PoolAddrW = $clog2(PoolDepth);
  localparam int unsigned TblW      = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned NfW       = $clog2(POOL_TABLES + 1);

  state_e               state_q, state_d;
  logic [NfW-1:0]       nf_q, nf_d;
  logic [PpnW-1:0]      base_q;
  logic [PoolAddrW-1:0] clr_q, clr_d;
  logic                 m_tvalid_q, m_tvalid_d;
  result_t              out_q, out_d;
  result_t              res_q, res_d;
  req_e                 req_q, req_d;
  logic [VaW-1:0]       va_q, va_d;
  logic [PpnW-1:0]      ppn_q, ppn_d;
  logic [FlagW-1:0]     flags_q, flags_d;
  logic [TblW-1:0]      t1_q, t1_d;
  logic [TblW-1:0]      t0_q, t0_d;

  logic                 root_we;
  logic [IdxW-1:0]      root_waddr, root_raddr;
  logic [EntryW-1:0]    root_wdata, root_rdata;
  logic                 pool_we;
  logic [PoolAddrW-1:0] pool_waddr, pool_raddr;
  logic [EntryW-1:0]    pool_wdata, pool_rdata;

  logic [EntryW-1:0]    ent;
  logic [PpnW-1:0]      dec_off;
  logic                 dec_hit;
  logic [TblW-1:0]      dec_tbl;
  logic                 pool_full;
  logic [EntryW-1:0]    link_ent;
  logic [PaW-1:0]       ent_page;
  logic [IdxW-1:0]      idx2, idx1, idx0;
  logic                 cfg_wr;

  assign idx2 = va_q[38:30];
  assign idx1 = va_q[29:21];
  assign idx0 = va_q[20:12];

  assign ent       = (state_q == ST_L2) ? root_rdata : pool_rdata;
  assign dec_off   = ent[EntryW-1:FlagW] - base_q;
  assign dec_hit   = dec_off < PpnW'(nf_q);
  assign dec_tbl   = dec_off[TblW-1:0];
  assign pool_full = nf_q == NfW'(POOL_TABLES);
  assign link_ent  = {base_q + PpnW'(nf_q), EntV};
  assign ent_page  = {ent[EntryW-1:FlagW], 12'h000};

  sv39pte_ram #(
    .Width (EntryW),
    .Depth (TblEntries)
  ) u_root_ram (
    .clk_i   (clk_i),
    .we_i    (root_we),
    .waddr_i (root_waddr),
    .wdata_i (root_wdata),
    .raddr_i (root_raddr),
    .rdata_o (root_rdata)
  );

  sv39pte_ram #(
    .Width (EntryW),
    .Depth (PoolDepth)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  always_comb begin
    state_d    = state_q;
    nf_d       = nf_q;
    clr_d      = clr_q;
    res_d      = res_q;
    req_d      = req_q;
    va_d       = va_q;
    ppn_d      = ppn_q;
    flags_d    = flags_q;
    t1_d       = t1_q;
    t0_d       = t0_q;
    root_we    = 1'b0;
    root_waddr = idx2;
    root_wdata = link_ent;
    root_raddr = s_tdata_i[40:32];
    pool_we    = 1'b0;
    pool_waddr = PoolAddrW'({t1_q, idx1});
    pool_wdata = link_ent;
    pool_raddr = PoolAddrW'({t1_q, idx1});

    unique case (state_q)
      ST_CLEAR: begin
        root_we    = 1'b1;
        root_waddr = clr_q[IdxW-1:0];
        root_wdata = '0;
        pool_we    = 1'b1;
        pool_waddr = clr_q;
        pool_wdata = '0;
        clr_d      = clr_q + PoolAddrW'(1);
        if (clr_q == PoolAddrW'(PoolDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          req_d   = req_e'(s_tdata_i[1:0]);
          va_d    = s_tdata_i[40:2];
          ppn_d   = s_tdata_i[96:53];
          flags_d = s_tdata_i[106:97];
          res_d   = '0;
          state_d = ST_L2;
        end
      end
      ST_L2: begin
        state_d = ST_DONE;
        unique case (req_q)
          REQ_MAP: begin
            if (ent[0]) begin
              if (dec_hit) begin
                t1_d    = dec_tbl;
                state_d = ST_RD1;
              end else begin
                res_d.status = 1'b1;
              end
            end else if (pool_full) begin
              res_d.status = 1'b1;
            end else begin
              root_we = 1'b1;
              t1_d    = nf_q[TblW-1:0];
              nf_d    = nf_q + NfW'(1);
              state_d = ST_RD1;
            end
          end
          REQ_UNMAP: begin
            if (ent[0] && dec_hit) begin
              t1_d    = dec_tbl;
              state_d = ST_RD1;
            end
          end
          REQ_XLATE: begin
            if (ent[0]) begin
              if ((ent[FlagW-1:0] & EntRwx) != '0) begin
                res_d.phys = ent_page | PaW'(va_q[29:0]);
              end else if (dec_hit) begin
                t1_d    = dec_tbl;
                state_d = ST_RD1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD1: begin
        state_d = ST_L1;
      end
      ST_L1: begin
        state_d = ST_DONE;
        unique case (req_q)
          REQ_MAP: begin
            if (ent[0]) begin
              if (dec_hit) begin
                t0_d    = dec_tbl;
                state_d = ST_WLEAF;
              end else begin
                res_d.status = 1'b1;
              end
            end else if (pool_full) begin
              res_d.status = 1'b1;
            end else begin
              pool_we = 1'b1;
              t0_d    = nf_q[TblW-1:0];
              nf_d    = nf_q + NfW'(1);
              state_d = ST_WLEAF;
            end
          end
          REQ_UNMAP: begin
            if (ent[0] && dec_hit) begin
              t0_d    = dec_tbl;
              state_d = ST_WLEAF;
            end
          end
          REQ_XLATE: begin
            if (ent[0]) begin
              if ((ent[FlagW-1:0] & EntRwx) != '0) begin
                res_d.phys = ent_page | PaW'(va_q[20:0]);
              end else if (dec_hit) begin
                t0_d    = dec_tbl;
                state_d = ST_RD0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_RD0: begin
        pool_raddr = PoolAddrW'({t0_q, idx0});
        state_d    = ST_L0;
      end
      ST_L0: begin
        if (ent[0]) begin
          res_d.phys = ent_page | PaW'(va_q[11:0]);
        end
        state_d = ST_DONE;
      end
      ST_WLEAF: begin
        pool_we     = 1'b1;
        pool_waddr  = PoolAddrW'({t0_q, idx0});
        pool_wdata  = (req_q == REQ_MAP) ? {ppn_q, flags_q | EntV | EntAd} : '0;
        res_d.flush = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    out_d      = out_q;
    if ((state_q == ST_DONE) && (!m_tvalid_q || m_tready_i)) begin
      m_tvalid_d = 1'b1;
      out_d      = res_q;
    end
  end

  assign cfg_wr = psel_i && penable_i && pwrite_i && (paddr_i == 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      nf_q       <= '0;
      clr_q      <= '0;
      base_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nf_q       <= nf_d;
      clr_q      <= clr_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_wr) begin
        base_q <= pwdata_i[PpnW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    res_q   <= res_d;
    req_q   <= req_d;
    va_q    <= va_d;
    ppn_q   <= ppn_d;
    flags_q <= flags_d;
    t1_q    <= t1_d;
    t0_q    <= t0_d;
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {6'b0, out_q.flush, out_q.phys, out_q.status};
  assign pready_o   = 1'b1;
  assign prdata_o   = (paddr_i == 1'b0) ? ApbDataW'(base_q) : '0;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the Sv39 page table engine: directed and random walks, checked by a scoreboard.

module tb;
  import sv39pte_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandItems   = 1250;
  localparam int unsigned PhaseCnt    = 6;
  localparam int unsigned DrainCycles = 12;
  localparam logic [0:0]  PoolBaseAddr = 1'b0;
  localparam logic [PpnW-1:0] PpnMax  = '1;

  class sv39_walk_scoreboard;
    logic [EntryW-1:0] root_ent [TblEntries];
    logic [EntryW-1:0] pool_ent [PoolTables*TblEntries];
    int unsigned       tables_used;
    logic [PpnW-1:0]   base_page;
    result_t           pending [$];
    int unsigned       mismatches;

    function new();
      foreach (root_ent[i]) root_ent[i] = '0;
      foreach (pool_ent[i]) pool_ent[i] = '0;
      tables_used = 0;
      base_page   = '0;
      mismatches  = 0;
    endfunction

    function bit table_of(logic [EntryW-1:0] ent, output int unsigned tbl);
      logic [PpnW-1:0] off;
      off = ent[EntryW-1:FlagW] - base_page;
      if (off >= tables_used) return 1'b0;
      tbl = int'(off);
      return 1'b1;
    endfunction

    // Follows a valid pointer, or links a fresh pool table into an empty slot.
    function bit walk_down(bit at_root, int unsigned slot, output int unsigned tbl);
      logic [EntryW-1:0] ent;
      logic [PpnW-1:0]   ppn;
      ent = at_root ? root_ent[slot] : pool_ent[slot];
      if (ent[0]) return table_of(ent, tbl);
      if (tables_used >= PoolTables) return 1'b0;
      tbl = tables_used;
      tables_used++;
      ppn = base_page + PpnW'(tbl);
      ent = {ppn, EntV};
      if (at_root) root_ent[slot] = ent;
      else pool_ent[slot] = ent;
      return 1'b1;
    endfunction

    function void note_request(req_e req, logic [VaW-1:0] va, logic [PaW-1:0] pa,
                               logic [FlagW-1:0] flags);
      result_t           res;
      int unsigned       i2, i1, i0, t1, t0;
      logic [EntryW-1:0] e2, e1, e0;
      res = '0;
      i2  = 32'(va[38:30]);
      i1  = 32'(va[29:21]);
      i0  = 32'(va[20:12]);
      case (req)
        REQ_MAP: begin
          if (walk_down(1'b1, i2, t1) && walk_down(1'b0, t1*TblEntries + i1, t0)) begin
            pool_ent[t0*TblEntries + i0] = {pa[PaW-1:12], flags | EntV | EntAd};
            res.flush = 1'b1;
          end else begin
            res.status = 1'b1;
          end
        end
        REQ_UNMAP: begin
          e2 = root_ent[i2];
          if (e2[0] && table_of(e2, t1)) begin
            e1 = pool_ent[t1*TblEntries + i1];
            if (e1[0] && table_of(e1, t0)) begin
              pool_ent[t0*TblEntries + i0] = '0;
              res.flush = 1'b1;
            end
          end
        end
        REQ_XLATE: begin
          e2 = root_ent[i2];
          if (e2[0]) begin
            if (|(e2[FlagW-1:0] & EntRwx)) begin
              res.phys = {e2[EntryW-1:FlagW], 12'b0} | va[29:0];
            end else if (table_of(e2, t1)) begin
              e1 = pool_ent[t1*TblEntries + i1];
              if (e1[0]) begin
                if (|(e1[FlagW-1:0] & EntRwx)) begin
                  res.phys = {e1[EntryW-1:FlagW], 12'b0} | va[20:0];
                end else if (table_of(e1, t0)) begin
                  e0 = pool_ent[t0*TblEntries + i0];
                  if (e0[0]) res.phys = {e0[EntryW-1:FlagW], 12'b0} | va[11:0];
                end
              end
            end
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    function void check_result(logic [OutDataW-1:0] word);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word expected none, actual %h", $time, word);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (word[0] !== want.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, want.status, word[0]);
        mismatches++;
      end
      if (word[PaW:1] !== want.phys) begin
        $display("%0t: phys_out expected %h, actual %h", $time, want.phys, word[PaW:1]);
        mismatches++;
      end
      if (word[PaW+1] !== want.flush) begin
        $display("%0t: flush_request expected %0d, actual %0d", $time, want.flush,
                 word[PaW+1]);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [0:0]          paddr     = '0;
  logic [ApbDataW-1:0] pwdata    = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  sv39_walk_scoreboard walk_sb = new();

  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  sv39_page_table_engine_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_o   (prdata),
    .pready_o   (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) walk_sb.check_result(m_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic push_request(req_e req, logic [VaW-1:0] va, logic [PaW-1:0] pa,
                              logic [FlagW-1:0] flags);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= InDataW'({flags, pa, va, req});
    do @(posedge clk_i); while (s_tready !== 1'b1);
    walk_sb.note_request(req, va, pa, flags);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Most addresses come from a few hot indices so that walks revisit existing tables.
  task automatic push_random();
    logic [8:0]       v2, v1, v0;
    int unsigned      pick;
    req_e             req;
    case ($urandom_range(0, 2))
      0:       v2 = 9'd0;
      1:       v2 = 9'd511;
      default: v2 = 9'd170;
    endcase
    if ($urandom_range(0, 19) == 0) v2 = 9'($urandom);
    case ($urandom_range(0, 3))
      0:       v1 = 9'd0;
      1:       v1 = 9'd511;
      2:       v1 = 9'd85;
      default: v1 = 9'd300;
    endcase
    if ($urandom_range(0, 9) == 0) v1 = 9'($urandom);
    case ($urandom_range(0, 3))
      0:       v0 = 9'd0;
      1:       v0 = 9'd1;
      2:       v0 = 9'd510;
      default: v0 = 9'd511;
    endcase
    if ($urandom_range(0, 9) < 3) v0 = 9'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) req = REQ_MAP;
    else if (pick < 55) req = REQ_UNMAP;
    else if (pick < 98) req = REQ_XLATE;
    else req = REQ_NONE;
    push_request(req, {v2, v1, v0, 12'($urandom)}, PaW'({$urandom, $urandom}),
                 FlagW'($urandom));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (walk_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_pool_base(logic [PpnW-1:0] base);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PoolBaseAddr;
    pwdata  <= ApbDataW'(base);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[PpnW-1:0] !== base) begin
      $display("%0t: pool_base_page expected %h, actual %h", $time, base, prdata[PpnW-1:0]);
      walk_sb.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    walk_sb.base_page = base;
  endtask

  function automatic logic [PpnW-1:0] phase_base(int unsigned phase);
    case (phase)
      1:       return PpnW'(1);
      3:       return PpnMax;
      5:       return PpnW'({$urandom, $urandom});
      default: return '0;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_pool_base('0);

    push_request(REQ_XLATE, '0, '0, '0);
    push_request(REQ_UNMAP, '0, '1, '1);
    push_request(REQ_MAP, '0, '0, '0);
    push_request(REQ_XLATE, 39'h0_0000_0ABC, '0, '0);
    push_request(REQ_MAP, '1, '1, '1);
    push_request(REQ_XLATE, '1, '0, '0);
    push_request(REQ_MAP, 39'h0_0000_0FFF, 56'h00_1234_5678_9ABC, 10'h00E);
    push_request(REQ_XLATE, 39'h0_0000_0123, '0, '0);
    push_request(REQ_MAP, 39'h0_0000_1000, 56'hAB_CDEF_0123_4FFF, 10'h2A5);
    push_request(REQ_XLATE, 39'h0_0000_1FFF, '0, '0);
    push_request(REQ_UNMAP, '0, '0, '0);
    push_request(REQ_UNMAP, '0, '0, '0);
    push_request(REQ_XLATE, '0, '0, '0);
    push_request(REQ_NONE, '1, '1, '1);
    push_request(REQ_UNMAP, {9'd511, 30'd0}, '0, '0);
    push_request(REQ_XLATE, {9'd511, 30'd0}, '0, '0);
    push_request(REQ_UNMAP, {9'd5, 30'd0}, '0, '0);
    push_request(REQ_XLATE, 39'h0_0000_1000, '0, '0);

    // A shifted pool base turns existing pointers into foreign or aliased tables.
    write_pool_base(PpnMax);
    push_request(REQ_XLATE, '1, '0, '0);
    push_request(REQ_MAP, {9'd256, 30'd0}, 56'h55_5555_5555_5000, 10'h155);
    push_request(REQ_XLATE, {9'd256, 30'h3FFF_FFFF}, '0, '0);
    push_request(REQ_UNMAP, '1, '0, '0);

    for (int unsigned phase = 0; phase < PhaseCnt; phase++) begin
      write_pool_base(phase_base(phase));
      repeat (RandItems / PhaseCnt) push_random();
    end

    settle();
    if (walk_sb.mismatches == 0 && walk_sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
